FILE: rtl/core/msb_first_bit_reader_macros.svh
// assertion macros for the msb-first bit reader checker
// no dependencies
`ifndef MSB_FIRST_BIT_READER_MACROS_SVH
`define MSB_FIRST_BIT_READER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BITR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitr check failed");

// antecedent implies consequent in the next cycle
`define BITR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitr check failed");

`endif

FILE: rtl/core/bitr_pkg.sv
// shared types and constants of the msb-first bit reader
// no dependencies
`timescale 1ns / 1ps

package bitr_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
  localparam int FRONT_BYTES = 4;
  localparam int POP_W       = $clog2(FRONT_BYTES + 1);
  localparam int WIN_W       = 8 + 8 * FRONT_BYTES;
  localparam int MAX_BITS    = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_value;
    logic [5:0] bit_count;
  } item_t;

  typedef struct packed {
    logic             push;
    logic [7:0]       push_byte;
    logic [POP_W-1:0] pop;
  } queue_cmd_t;

  typedef struct packed {
    logic [QCW-1:0]               count;
    logic [FRONT_BYTES-1:0][7:0]  front;
  } queue_view_t;

  typedef struct packed {
    logic [31:0] field_value;
    logic [1:0]  status;
    logic        commit;
    logic [5:0]  bits;
    logic [7:0]  held_byte;
    logic [2:0]  held_count;
  } unpack_t;

endpackage

FILE: rtl/core/bitr_in_stage.sv
// input register slot of the bit reader
// depends on bitr_pkg
`timescale 1ns / 1ps

module bitr_in_stage
  import bitr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  take,
  output logic  slot_valid,
  output item_t slot_item
);

  logic slot_valid_next;
  logic load;

  assign in_stall        = slot_valid & ~take;
  assign load            = in_valid & ~in_stall;
  assign slot_valid_next = load | (slot_valid & ~take);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_item <= in_item;
    end
  end

endmodule

FILE: rtl/core/bitr_queue.sv
// shifting byte queue, oldest byte at entry zero
// depends on bitr_pkg
`timescale 1ns / 1ps

module bitr_queue
  import bitr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_cmd_t  cmd,
  output queue_view_t view
);

  logic [7:0]     q   [QUEUE_DEPTH];
  logic [7:0]     ext [QUEUE_DEPTH + FRONT_BYTES];
  logic [QCW-1:0] count;
  logic [QCW-1:0] count_next;

  assign count_next = count + QCW'(cmd.push) - QCW'(cmd.pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH + FRONT_BYTES; i++) begin : g_ext
      if (i < QUEUE_DEPTH) begin : g_real
        assign ext[i] = q[i];
      end else begin : g_pad
        assign ext[i] = 8'd0;
      end
    end

    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
      logic [7:0] shifted;

      always_comb begin
        case (cmd.pop)
          POP_W'(1): shifted = ext[i + 1];
          POP_W'(2): shifted = ext[i + 2];
          POP_W'(3): shifted = ext[i + 3];
          POP_W'(4): shifted = ext[i + 4];
          default:   shifted = q[i];
        endcase
      end

      always_ff @(posedge clk) begin
        if (cmd.push && count[QAW-1:0] == QAW'(i)) begin
          q[i] <= cmd.push_byte;
        end else if (cmd.pop != '0) begin
          q[i] <= shifted;
        end
      end
    end

    for (i = 0; i < FRONT_BYTES; i++) begin : g_front
      assign view.front[i] = q[i];
    end
  endgenerate

  assign view.count = count;

endmodule

FILE: rtl/core/bitr_unpack.sv
// field extraction and state update for one beat
// depends on bitr_pkg
`timescale 1ns / 1ps

module bitr_unpack
  import bitr_pkg::*;
(
  input  item_t       item,
  input  queue_view_t view,
  input  logic [7:0]  held_byte,
  input  logic [2:0]  held_count,
  output unpack_t     res,
  output queue_cmd_t  cmd
);

  logic [5:0]       n;
  logic [WIN_W-1:0] aligned;
  logic [WIN_W-1:0] window;
  logic             short_read;
  logic [5:0]       rest;
  logic [5:0]       rest_up;
  logic [2:0]       nbytes;
  logic [1:0]       last_idx;
  logic             underflow;
  logic             full;

  assign n = (item.bit_count > 6'(MAX_BITS)) ? 6'(MAX_BITS) : item.bit_count;

  // stream bits start at the top of the window
  assign aligned = {held_byte, view.front[0], view.front[1], view.front[2], view.front[3]}
                   << (4'd8 - {1'b0, held_count});
  assign window  = aligned >> (6'(WIN_W) - n);

  assign short_read = n <= {3'd0, held_count};
  assign rest       = n - {3'd0, held_count};
  assign rest_up    = rest + 6'd7;
  assign nbytes     = rest_up[5:3];
  assign last_idx   = 2'(nbytes - 3'd1);
  assign underflow  = ~short_read & (QCW'(nbytes) > view.count);
  assign full       = view.count == QCW'(QUEUE_DEPTH);

  always_comb begin
    res.field_value = 32'd0;
    res.status      = ST_OK;
    res.commit      = 1'b0;
    res.bits        = n;
    res.held_byte   = held_byte;
    res.held_count  = held_count;
    cmd.push        = 1'b0;
    cmd.push_byte   = item.byte_value;
    cmd.pop         = '0;
    if (item.op == OP_PUSH) begin
      if (full) begin
        res.status = ST_OVERFLOW;
      end else begin
        cmd.push = 1'b1;
      end
    end else if (underflow) begin
      res.status = ST_UNDERFLOW;
    end else begin
      res.field_value = window[31:0];
      res.commit      = 1'b1;
      if (short_read) begin
        res.held_count = held_count - n[2:0];
      end else begin
        res.held_count = 3'd0 - rest[2:0];
        res.held_byte  = view.front[last_idx];
        cmd.pop        = POP_W'(nbytes);
      end
    end
  end

endmodule

FILE: rtl/core/msb_first_bit_reader.sv
// msb-first bit reader top level: input slot, byte queue, extraction, result register
// depends on bitr_pkg, bitr_in_stage, bitr_queue, bitr_unpack
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid / in_stall): op 0 pushes byte_value into an
//   eight-byte queue, op 1 reads the next bit_count bits (0..32, larger
//   counts read 32) of the stream, most significant bit first.
//   Output channel (out_valid / out_stall): one beat per input beat, in
//   order, with field_value, status (ok, read underflow, push overflow)
//   and the running bits_read_total.
//   Throughput: one beat per cycle while the output is not stalled;
//   extraction of up to four queued bytes plus the held bits is a single
//   combinational pass between the input slot and the result register.
//   Path: a beat is registered in the input slot, then in the result register.
//   Stall: while out_stall holds a result, the input slot keeps one more
//   beat and then raises in_stall; nothing is lost or repeated.
//   Reset (rst, synchronous): empties the queue and both registers,
//   clears the held bits and the bit total. Queue storage is not cleared.
//
module msb_first_bit_reader
  import bitr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  byte_value,
  input  logic [5:0]  bit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] field_value,
  output logic [1:0]  status,
  output logic [31:0] bits_read_total
);

  item_t       in_item;
  item_t       slot_item;
  logic        slot_valid;
  logic        adv;
  queue_view_t view;
  queue_cmd_t  cmd_raw;
  queue_cmd_t  cmd;
  unpack_t     res;

  logic [7:0]  held_byte;
  logic [2:0]  held_count;
  logic [31:0] bits_read_count;
  logic [31:0] bits_read_count_next;
  logic        out_valid_next;

  assign in_item = '{op: op, byte_value: byte_value, bit_count: bit_count};
  assign adv     = slot_valid & (~out_valid | ~out_stall);

  bitr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (adv),
    .slot_valid (slot_valid),
    .slot_item  (slot_item)
  );

  bitr_unpack u_unpack (
    .item       (slot_item),
    .view       (view),
    .held_byte  (held_byte),
    .held_count (held_count),
    .res        (res),
    .cmd        (cmd_raw)
  );

  always_comb begin
    cmd = cmd_raw;
    if (!adv) begin
      cmd.push = 1'b0;
      cmd.pop  = '0;
    end
  end

  bitr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .view (view)
  );

  assign bits_read_count_next = res.commit ? bits_read_count + 32'(res.bits)
                                           : bits_read_count;
  assign out_valid_next       = adv | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte       <= 8'd0;
      held_count      <= 3'd0;
      bits_read_count <= 32'd0;
      out_valid       <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (adv) begin
        held_byte       <= res.held_byte;
        held_count      <= res.held_count;
        bits_read_count <= bits_read_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      field_value     <= res.field_value;
      status          <= res.status;
      bits_read_total <= bits_read_count_next;
    end
  end

endmodule

FILE: rtl/core/bitr_checker.sv
// port-level checks of the msb-first bit reader, bound to the top level
// depends on bitr_pkg, msb_first_bit_reader_macros.svh and msb_first_bit_reader
`timescale 1ns / 1ps
`include "msb_first_bit_reader_macros.svh"

module bitr_checker
  import bitr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        op,
  input logic [7:0]  byte_value,
  input logic [5:0]  bit_count,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] field_value,
  input logic [1:0]  status,
  input logic [31:0] bits_read_total
);

  // input only backs up behind a held result
  `BITR_ASSERT_SAME(a_stall_needs_held_result, clk, rst, in_stall, out_valid && out_stall)

  // failed beats carry no bits
  `BITR_ASSERT_SAME(a_fail_zero_value, clk, rst, out_valid && status != ST_OK, field_value == 32'd0)

  `BITR_ASSERT_SAME(a_status_code, clk, rst, out_valid, status <= ST_OVERFLOW)

  `BITR_ASSERT_NEXT(a_out_held, clk, rst, out_valid && out_stall, out_valid)

endmodule

bind msb_first_bit_reader bitr_checker u_bitr_checker (.*);

FILE: dv/tb.sv
// testbench for the msb-first bit reader: directed stream cases, then random
// push/read streams under varied sender and receiver idling
// depends on bitr_pkg and msb_first_bit_reader
`timescale 1ns / 1ps

module tb;
  import bitr_pkg::*;

  typedef struct packed {
    logic [31:0] field_value;
    logic [1:0]  status;
    logic [31:0] bits_read_total;
  } reader_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_PUSH;
  logic [7:0]  byte_value = 8'h00;
  logic [5:0]  bit_count = 6'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] field_value;
  logic [1:0]  status;
  logic [31:0] bits_read_total;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;

  // predicted reader state
  logic [7:0]  stream_bytes [QUEUE_DEPTH];
  int          stream_head = 0;
  int          stream_fill = 0;
  logic [7:0]  held_bits_byte = 8'h00;
  int          held_bits_count = 0;
  logic [31:0] bit_total = 32'd0;

  int pushes_taken = 0;
  int pushes_dropped = 0;
  int reads_done = 0;
  int reads_short = 0;

  reader_result_t pending_fields[$];

  msb_first_bit_reader DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .byte_value      (byte_value),
    .bit_count       (bit_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .field_value     (field_value),
    .status          (status),
    .bits_read_total (bits_read_total)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic reader_result_t predict_field(input item_t it);
    reader_result_t res;
    int             n;
    int             rest;
    int             nbytes;
    int             keep;
    logic [63:0]    word;
    logic [63:0]    value;
    res = '0;
    res.status = ST_OK;
    word = 64'd0;
    value = 64'd0;
    if (it.op == OP_PUSH) begin
      if (stream_fill >= QUEUE_DEPTH) begin
        res.status = ST_OVERFLOW;
        pushes_dropped++;
      end else begin
        stream_bytes[(stream_head + stream_fill) % QUEUE_DEPTH] = it.byte_value;
        stream_fill++;
        pushes_taken++;
      end
    end else begin
      n = (it.bit_count > MAX_BITS) ? MAX_BITS : int'(it.bit_count);
      if (n != 0 && n <= held_bits_count) begin
        value = ({56'd0, held_bits_byte} >> (held_bits_count - n)) & ((64'd1 << n) - 64'd1);
        held_bits_count -= n;
        bit_total += 32'(n);
        reads_done++;
      end else if (n != 0) begin
        rest = n - held_bits_count;
        nbytes = (rest + 7) / 8;
        if (nbytes > stream_fill) begin
          res.status = ST_UNDERFLOW;
          reads_short++;
        end else begin
          value = ({56'd0, held_bits_byte} & ((64'd1 << held_bits_count) - 64'd1)) << rest;
          for (int i = 0; i < nbytes; i++) begin
            word = (word << 8) | {56'd0, stream_bytes[stream_head]};
            stream_head = (stream_head + 1) % QUEUE_DEPTH;
            stream_fill--;
          end
          keep = (8 - (rest % 8)) % 8;
          value = value | (word >> keep);
          held_bits_count = keep;
          held_bits_byte = word[7:0];
          bit_total += 32'(n);
          reads_done++;
        end
      end else begin
        reads_done++;
      end
      res.field_value = value[31:0];
    end
    res.bits_read_total = bit_total;
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    reader_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_fields.size() == 0) begin
        error_count++;
        $display("%0t unexpected beat: field_value %h status %0d total %0d",
                 $time, field_value, status, bits_read_total);
      end else begin
        want = pending_fields.pop_front();
        if (field_value !== want.field_value) begin
          error_count++;
          $display("%0t field_value: expected %h, actual %h",
                   $time, want.field_value, field_value);
        end
        if (status !== want.status) begin
          error_count++;
          $display("%0t status: expected %0d, actual %0d", $time, want.status, status);
        end
        if (bits_read_total !== want.bits_read_total) begin
          error_count++;
          $display("%0t bits_read_total: expected %0d, actual %0d",
                   $time, want.bits_read_total, bits_read_total);
        end
      end
    end
  end

  task automatic send_beat(input item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    byte_value <= it.byte_value;
    bit_count <= it.bit_count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_fields.push_back(predict_field(it));
  endtask

  task automatic push_byte(input logic [7:0] b);
    item_t it;
    it.op = OP_PUSH;
    it.byte_value = b;
    it.bit_count = 6'($urandom_range(0, 63));
    send_beat(it);
  endtask

  task automatic read_field(input int n);
    item_t it;
    it.op = OP_READ;
    it.byte_value = 8'($urandom_range(0, 255));
    it.bit_count = 6'(n);
    send_beat(it);
  endtask

  // sender holds off until every result is back
  task automatic drain_pause();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_reads();
    read_field(0);
    read_field(1);
    read_field(63);
  endtask

  task automatic test_queue_limits();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_byte(8'h80);
    push_byte(8'h01);
    push_byte(8'h7F);
    push_byte(8'hFE);
    push_byte(8'h3C);
    read_field(32);
    read_field(40);
    read_field(1);
  endtask

  task automatic test_held_bits();
    push_byte(8'hFF);
    read_field(3);
    read_field(5);
    push_byte(8'hC3);
    push_byte(8'h99);
    push_byte(8'h18);
    push_byte(8'hE7);
    push_byte(8'h42);
    read_field(3);
    read_field(32);
    read_field(0);
    read_field(6);
  endtask

  task automatic test_random_streams(input int beats, input int send_pct, input int recv_pct);
    int    r;
    int    n;
    int    eff;
    int    avail;
    item_t it;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < beats; i++) begin
      if (i == beats / 2) drain_pause();
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(0, MAX_BITS);
      eff = (n > MAX_BITS) ? MAX_BITS : n;
      avail = held_bits_count + 8 * stream_fill;
      if (r < 6) begin
        it.op = 1'($urandom_range(0, 1));
        it.byte_value = 8'($urandom_range(0, 255));
        it.bit_count = 6'($urandom_range(0, 63));
        send_beat(it);
      end else if (stream_fill == QUEUE_DEPTH && r < 14) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (stream_fill < QUEUE_DEPTH && (avail < eff || r < 45)) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        read_field(n);
      end
    end
  endtask

  initial begin
    int guard;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 8;
    recv_stall_pct = 54;
    test_reset_reads();
    test_queue_limits();
    test_held_bits();
    test_random_streams(700, 8, 54);
    test_random_streams(700, 54, 8);
    test_random_streams(600, 0, 0);
    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    guard = 0;
    while (pending_fields.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_fields.size() != 0) begin
      error_count++;
      $display("%0t %0d results never arrived", $time, pending_fields.size());
    end
    $display("covered %0d pushes (%0d dropped on a full queue), %0d reads (%0d underflows)",
             pushes_taken + pushes_dropped, pushes_dropped, reads_done + reads_short,
             reads_short);
    $display("final bit total %0d, %0d mismatches", bit_total, error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

endmodule
